@@ rtl/foe_pkg.sv @@
`timescale 1ns / 1ps

package foe_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 200;
  localparam int FRAME_HEIGHT = 200;
  localparam int ROW_BYTES    = (FRAME_WIDTH + 7) / 8;
  localparam int FRAME_BYTES  = ROW_BYTES * FRAME_HEIGHT;
  localparam int ADDR_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int COL_W        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

  // transaction field widths
  localparam int COORD_W = 9;
  localparam int PIDX_W  = 15;

  // panel index / ROW_BYTES by reciprocal multiply, exact for 15-bit indices
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + ROW_BYTES - 1) / ROW_BYTES;
  localparam int PROD_W      = PIDX_W + RECIP_SHIFT + 1;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [7:0] WHITE_BYTE = 8'hFF;
  localparam logic [7:0] BLACK_BYTE = 8'h00;

  // register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_MIRROR_X  = 2'd0,
    REG_MIRROR_Y  = 2'd1,
    REG_SWAP_AXES = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_FILL,
    OP_PIXEL,
    OP_READ,
    OP_REJECT
  } op_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               colour_black;
    logic [PIDX_W-1:0]  panel_index;
  } in_t;

  typedef struct packed {
    logic       status;
    logic [7:0] panel_byte;
  } out_t;

  typedef struct packed {
    logic mirror_x;
    logic mirror_y;
    logic swap_axes;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic               colour_black;
    logic [ADDR_W-1:0]  addr;
    logic [2:0]         bit_pos;
    logic [COORD_W-1:0] row;
    logic [COL_W-1:0]   col;
  } cmd_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_EST,
    FS_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_FILL,
    BS_PIX_RD,
    BS_PIX_WR,
    BS_READ,
    BS_DONE
  } back_state_e;

endpackage

@@ rtl/foe_front.sv @@
`timescale 1ns / 1ps

module foe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  foe_pkg::in_t  in_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          init_busy_i,
  output foe_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import foe_pkg::*;

  front_state_e          state_q, state_d;
  in_t                   item_q;
  cmd_t                  cmd_q, cmd_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [15:0]           pix_addr;
  logic [COORD_W-1:0]    quot;
  logic [PIDX_W-1:0]     rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (state_q == FS_EST) begin
      cmd_q  <= cmd_d;
      prod_q <= prod_d;
    end
  end

  // classify and range check
  always_comb begin
    pix_addr = 16'(item_q.pos_y) * 16'(ROW_BYTES) + 16'(item_q.pos_x[COORD_W-1:3]);
    prod_d   = PROD_W'(item_q.panel_index) * PROD_W'(RECIP);
    cmd_d              = '0;
    cmd_d.colour_black = item_q.colour_black;
    cmd_d.addr         = pix_addr[ADDR_W-1:0];
    cmd_d.bit_pos      = item_q.pos_x[2:0];
    case (kind_e'(item_q.kind))
      KIND_FILL: begin
        cmd_d.op = OP_FILL;
      end
      KIND_PIXEL: begin
        if ((10'(item_q.pos_x) < 10'(FRAME_WIDTH)) &&
            (10'(item_q.pos_y) < 10'(FRAME_HEIGHT))) begin
          cmd_d.op = OP_PIXEL;
        end else begin
          cmd_d.op = OP_REJECT;
        end
      end
      KIND_READ: begin
        if (16'(item_q.panel_index) < 16'(FRAME_BYTES)) begin
          cmd_d.op = OP_READ;
        end else begin
          cmd_d.op = OP_REJECT;
        end
      end
      default: begin
        cmd_d.op = OP_REJECT;
      end
    endcase
  end

  // panel row and byte column from the registered product
  always_comb begin
    quot      = prod_q[RECIP_SHIFT +: COORD_W];
    rem       = item_q.panel_index - PIDX_W'(16'(quot) * 16'(ROW_BYTES));
    cmd_o     = cmd_q;
    cmd_o.row = quot;
    cmd_o.col = rem[COL_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_valid_o = 1'b0;
    case (state_q)
      FS_IDLE: begin
        in_ready_o = !init_busy_i;
        if (in_valid_i && !init_busy_i) begin
          state_d = FS_EST;
        end
      end
      FS_EST: begin
        state_d = FS_PUSH;
      end
      FS_PUSH: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/foe_fifo.sv @@
`timescale 1ns / 1ps

module foe_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  foe_pkg::cmd_t cmd_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output foe_pkg::cmd_t cmd_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);
  import foe_pkg::*;

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              push, pop;

  function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] ptr);
    if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  assign push_ready_o = (count_q != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign cmd_o        = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      count_q <= count_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/foe_back.sv @@
`timescale 1ns / 1ps

module foe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  foe_pkg::cfg_t cfg_i,
  input  foe_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  output foe_pkg::out_t out_data_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          init_busy_o
);
  import foe_pkg::*;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [2:0]        slot;

  logic [7:0]        mem_q [FRAME_BYTES];
  logic [7:0]        rdata_q;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [7:0]        wdata, mask;
  logic              we;

  logic              hit_q, hit_d;
  logic [2:0]        bsel_q;
  logic              res_status_q, res_status_d;
  logic [7:0]        res_byte_q, res_byte_d;
  out_t              out_q;
  logic              out_valid_q, out_load;

  logic [9:0]        px, ux, uy, lx, ly;
  logic              pix_in;
  logic [15:0]       map_addr;

  // panel pixel -> logical pixel for the current slot
  always_comb begin
    px       = (10'(cmd_q.col) << 3) + 10'(cnt_q[2:0]);
    ux       = cfg_i.mirror_x ? (10'(FRAME_WIDTH - 1) - px) : px;
    uy       = cfg_i.mirror_y ? (10'(FRAME_HEIGHT - 1) - 10'(cmd_q.row)) : 10'(cmd_q.row);
    lx       = cfg_i.swap_axes ? uy : ux;
    ly       = cfg_i.swap_axes ? ux : uy;
    pix_in   = (px < 10'(FRAME_WIDTH)) && (lx < 10'(FRAME_WIDTH)) &&
               (ly < 10'(FRAME_HEIGHT));
    map_addr = 16'(ly) * 16'(ROW_BYTES) + 16'(lx[9:3]);
  end

  assign slot        = cnt_q[2:0] - 3'd1;
  assign mask        = 8'h80 >> cmd_q.bit_pos;
  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_byte_d   = res_byte_q;
    hit_d        = 1'b0;
    raddr        = cmd_q.addr;
    waddr        = sweep_q;
    wdata        = WHITE_BYTE;
    we           = 1'b0;
    cmd_ready_o  = 1'b0;
    out_load     = 1'b0;
    init_busy_o  = 1'b0;
    case (state_q)
      BS_CLEAR: begin
        init_busy_o = 1'b1;
        we          = 1'b1;
        if (sweep_q == ADDR_W'(FRAME_BYTES - 1)) begin
          sweep_d = '0;
          state_d = BS_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      BS_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          res_status_d = 1'b0;
          res_byte_d   = BLACK_BYTE;
          cnt_d        = '0;
          sweep_d      = '0;
          case (cmd_i.op)
            OP_FILL: begin
              state_d = BS_FILL;
            end
            OP_PIXEL: begin
              state_d = BS_PIX_RD;
            end
            OP_READ: begin
              res_byte_d = WHITE_BYTE;
              state_d    = BS_READ;
            end
            default: begin
              res_status_d = 1'b1;
              state_d      = BS_DONE;
            end
          endcase
        end
      end
      BS_FILL: begin
        we    = 1'b1;
        wdata = cmd_q.colour_black ? BLACK_BYTE : WHITE_BYTE;
        if (sweep_q == ADDR_W'(FRAME_BYTES - 1)) begin
          state_d = BS_DONE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      BS_PIX_RD: begin
        state_d = BS_PIX_WR;
      end
      BS_PIX_WR: begin
        we      = 1'b1;
        waddr   = cmd_q.addr;
        wdata   = cmd_q.colour_black ? (rdata_q & ~mask) : (rdata_q | mask);
        state_d = BS_DONE;
      end
      BS_READ: begin
        // issue slot cnt, consume slot cnt-1 from the registered read data
        raddr = map_addr[ADDR_W-1:0];
        hit_d = !cnt_q[3] && pix_in;
        if (hit_q && !rdata_q[3'd7 - bsel_q]) begin
          res_byte_d[3'd7 - slot] = 1'b0;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[3]) begin
          state_d = BS_DONE;
        end
      end
      BS_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_CLEAR;
      sweep_q     <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    bsel_q       <= lx[2:0];
    res_status_q <= res_status_d;
    res_byte_q   <= res_byte_d;
    if (out_load) begin
      out_q.status     <= res_status_q;
      out_q.panel_byte <= res_byte_q;
    end
  end

  // frame store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

endmodule

@@ rtl/framebuffer_orientation_engine.sv @@
`timescale 1ns / 1ps
// the back end works on one transaction at a time from its frame store: a panel byte
// read issues eight byte reads, one per panel pixel; a pixel write is a read-modify-write;
// a fill writes every byte; a rejected transaction only returns its status
// reset: async active low; afterwards a clearing pass writes white to all FRAME_BYTES
// bytes (5000 here), one a cycle, with in_ready_o held low until it ends

module framebuffer_orientation_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input transactions
  input  foe_pkg::in_t                  in_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  // result transactions
  output foe_pkg::out_t                 out_data_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [foe_pkg::PADDR_W-1:0]   paddr,
  input  logic [foe_pkg::PDATA_W-1:0]   pwdata,
  output logic [foe_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import foe_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     reg_wr;

  cmd_t     front_cmd, queue_cmd;
  logic     front_valid, front_ready;
  logic     queue_valid, queue_ready;
  logic     init_busy;

  // registers: byte address 4*i, one bit each, zero-wait access
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_MIRROR_X: begin
          cfg_q.mirror_x <= pwdata[0];
        end
        REG_MIRROR_Y: begin
          cfg_q.mirror_y <= pwdata[0];
        end
        REG_SWAP_AXES: begin
          cfg_q.swap_axes <= pwdata[0];
        end
        default: begin
          // writes outside the register map are dropped
        end
      endcase
    end
  end

  // read data, zero outside the map
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MIRROR_X: begin
        prdata[0] = cfg_q.mirror_x;
      end
      REG_MIRROR_Y: begin
        prdata[0] = cfg_q.mirror_y;
      end
      REG_SWAP_AXES: begin
        prdata[0] = cfg_q.swap_axes;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // front: takes a transaction, range checks it, splits the panel index into
  // row and byte column, and queues a command
  foe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .init_busy_i (init_busy),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // short command queue so the front keeps accepting while the back is busy
  foe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .cmd_o        (queue_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  // back: owns the frame store; sweeps for fill and reset clear, does the
  // read-modify-write for pixels and gathers eight pixels for a panel byte
  // into the output register
  foe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .init_busy_o (init_busy)
  );

endmodule

@@ rtl/foe_checker.sv @@
`timescale 1ns / 1ps

module foe_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input foe_pkg::out_t out_data_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic          pready
);

  logic [3:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // transactions taken whose result is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !in_ready_o && !out_valid_o && pready)
    else $error("ports active during reset");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != 4'd0))
    else $error("result without an outstanding transaction");

  a_error_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> (out_data_o.panel_byte == 8'h00))
    else $error("error result carries a nonzero panel byte");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

endmodule

bind framebuffer_orientation_engine foe_checker u_foe_checker (.*);

@@ tb/framebuffer_orientation_engine_tb.sv @@
`timescale 1ns / 1ps

module framebuffer_orientation_engine_tb;
  import foe_pkg::*;

  // kind code that the block has to reject
  localparam logic [1:0] KIND_BAD     = 2'd3;
  localparam logic       STATUS_OK    = 1'b0;
  localparam logic       STATUS_RANGE = 1'b1;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 230;
  localparam int HOLD_CYCLES   = 400;
  // a fill walks the whole store, and reset is followed by a clearing pass
  localparam int QUIET_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t result;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  in_t  in_data     = '0;
  logic in_valid    = 1'b0;
  logic in_ready_o;
  out_t out_data_o;
  logic out_valid_o;
  logic out_ready   = 1'b0;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // typed-in result travelling alongside the transaction on offer
  bit   row_typed        = 1'b0;
  out_t row_typed_result = '0;

  // shadow of the block's state and orientation registers
  logic [7:0] frame_shadow [FRAME_BYTES];
  logic       mirror_x_q  = 1'b0;
  logic       mirror_y_q  = 1'b0;
  logic       swap_axes_q = 1'b0;

  out_t pending_responses [$];
  int   mismatch_count = 0;
  int   quiet_cycles   = 0;
  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;
  bit   hold_request   = 1'b0;

  stim_row_t directed_rows [$];

  framebuffer_orientation_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected response of one transaction; updates the frame shadow as the block would
  function automatic out_t expected_response(in_t t);
    out_t        r;
    int unsigned py, col, px, ux, uy, lx, ly, idx;
    r = '0;
    case (t.kind)
      KIND_FILL: begin
        foreach (frame_shadow[i]) frame_shadow[i] = t.colour_black ? BLACK_BYTE : WHITE_BYTE;
      end
      KIND_PIXEL: begin
        if (t.pos_x >= FRAME_WIDTH || t.pos_y >= FRAME_HEIGHT) begin
          r.status = STATUS_RANGE;
        end else begin
          idx = t.pos_y * ROW_BYTES + (t.pos_x >> 3);
          // black clears the bit, white sets it
          frame_shadow[idx][7 - (t.pos_x % 8)] = ~t.colour_black;
        end
      end
      KIND_READ: begin
        if (t.panel_index >= FRAME_BYTES) begin
          r.status = STATUS_RANGE;
        end else begin
          py           = t.panel_index / ROW_BYTES;
          col          = t.panel_index % ROW_BYTES;
          r.panel_byte = WHITE_BYTE;
          for (int b = 0; b < 8; b++) begin
            px = col * 8 + b;
            // padding pixels past the right edge stay white
            if (px < FRAME_WIDTH) begin
              ux = mirror_x_q ? (FRAME_WIDTH - 1 - px) : px;
              uy = mirror_y_q ? (FRAME_HEIGHT - 1 - py) : py;
              lx = swap_axes_q ? uy : ux;
              ly = swap_axes_q ? ux : uy;
              // logical pixels off the frame read white
              if (lx < FRAME_WIDTH && ly < FRAME_HEIGHT) begin
                if (!frame_shadow[ly * ROW_BYTES + lx / 8][7 - (lx % 8)]) begin
                  r.panel_byte[7 - b] = 1'b0;
                end
              end
            end
          end
        end
      end
      default: begin
        r.status = STATUS_RANGE;
      end
    endcase
    return r;
  endfunction

  function automatic in_t make_item(logic [1:0] kind, int x, int y, bit black, int pidx);
    in_t t;
    t.kind         = kind;
    t.pos_x        = COORD_W'(x);
    t.pos_y        = COORD_W'(y);
    t.colour_black = black;
    t.panel_index  = PIDX_W'(pidx);
    return t;
  endfunction

  function automatic out_t make_result(logic status, logic [7:0] panel_byte);
    out_t r;
    r.status     = status;
    r.panel_byte = panel_byte;
    return r;
  endfunction

  // coordinate near one of the two ends of a range, so writes and reads meet at corners
  function automatic int corner_coord(int span);
    if ($urandom_range(0, 1)) begin
      return $urandom_range(0, 15);
    end else begin
      return span - 1 - $urandom_range(0, 15);
    end
  endfunction

  function automatic in_t random_transaction();
    in_t t;
    int  pick;
    int  row;
    int  col;
    // every field random first, then the fields that matter are shaped
    t.kind         = 2'($urandom);
    t.pos_x        = COORD_W'($urandom);
    t.pos_y        = COORD_W'($urandom);
    t.colour_black = 1'($urandom);
    t.panel_index  = PIDX_W'($urandom);
    pick           = $urandom_range(0, 999);
    if (pick < 15) begin
      t.kind = KIND_FILL;
    end else if (pick < 480) begin
      t.kind = KIND_PIXEL;
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 1)) begin
          t.pos_x = COORD_W'(corner_coord(FRAME_WIDTH));
          t.pos_y = COORD_W'(corner_coord(FRAME_HEIGHT));
        end else begin
          t.pos_x = COORD_W'($urandom_range(0, FRAME_WIDTH - 1));
          t.pos_y = COORD_W'($urandom_range(0, FRAME_HEIGHT - 1));
        end
      end
    end else if (pick < 960) begin
      t.kind = KIND_READ;
      if ($urandom_range(0, 11) != 0) begin
        if ($urandom_range(0, 1)) begin
          row = corner_coord(FRAME_HEIGHT);
          col = corner_coord(ROW_BYTES) % ROW_BYTES;
          t.panel_index = PIDX_W'(row * ROW_BYTES + col);
        end else begin
          t.panel_index = PIDX_W'($urandom_range(0, FRAME_BYTES - 1));
        end
      end
    end else begin
      t.kind = KIND_BAD;
    end
    return t;
  endfunction

  // offer one transaction and return at the edge where it is taken
  task automatic offer(in_t item, bit typed, out_t typed_result);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_data          <= item;
    row_typed        <= typed;
    row_typed_result <= typed_result;
    in_valid         <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // one register write: setup cycle, then access cycle until pready
  task automatic write_reg(reg_idx_e idx, logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    // only bit 0 is meaningful, the rest is noise
    pwdata  <= {$urandom} & ~PDATA_W'(1) | PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MIRROR_X:  mirror_x_q  = value;
      REG_MIRROR_Y:  mirror_y_q  = value;
      REG_SWAP_AXES: swap_axes_q = value;
      default: ;
    endcase
  endtask

  task automatic set_orientation(logic [2:0] orient);
    write_reg(REG_MIRROR_X, orient[0]);
    write_reg(REG_MIRROR_Y, orient[1]);
    write_reg(REG_SWAP_AXES, orient[2]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // waits on the clock before checking, so the monitor has logged the last accepted transaction
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  // transaction monitor: predicts on input handshakes, checks on result handshakes
  always @(posedge clk_i) begin : monitor
    out_t predicted;
    out_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        // the shadow always advances, even when the row carries its own result
        predicted = expected_response(in_data);
        pending_responses.push_back(row_typed ? row_typed_result : predicted);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready) begin
        moved = 1'b1;
        if (pending_responses.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("result with no transaction pending: status %0d byte %02h",
                     out_data_o.status, out_data_o.panel_byte);
          end
          mismatch_count++;
        end else begin
          want = pending_responses.pop_front();
          if (out_data_o.status !== want.status ||
              out_data_o.panel_byte !== want.panel_byte) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("mismatch at %0t: status exp %0d got %0d, byte exp %02h got %02h",
                       $realtime, want.status, out_data_o.status,
                       want.panel_byte, out_data_o.panel_byte);
            end
            mismatch_count++;
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    do @(posedge clk_i); while (quiet_cycles < QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [2:0] orient_seq [PHASES];
    stim_row_t  row;

    // falling edge at time zero so the block resets before the first clock
    rst_ni <= 1'b0;
    foreach (frame_shadow[i]) frame_shadow[i] = WHITE_BYTE;
    // orientations per phase, both extremes included
    orient_seq = '{3'b111, 3'b001, 3'b110, 3'b010, 3'b101, 3'b000, 3'b011, 3'b100};

    // directed rows, run with the reset orientation
    // fresh frame reads white, out-of-range reads and bad kinds are rejected
    directed_rows.push_back('{make_item(KIND_READ, 0, 0, 0, 0), 1,
                              make_result(STATUS_OK, WHITE_BYTE)});
    directed_rows.push_back('{make_item(KIND_READ, 0, 0, 0, FRAME_BYTES - 1), 1,
                              make_result(STATUS_OK, WHITE_BYTE)});
    directed_rows.push_back('{make_item(KIND_READ, 0, 0, 0, FRAME_BYTES), 1,
                              make_result(STATUS_RANGE, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_READ, 511, 511, 1, 32767), 1,
                              make_result(STATUS_RANGE, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_BAD, 511, 511, 1, 32767), 1,
                              make_result(STATUS_RANGE, BLACK_BYTE)});
    // pixel writes just off the frame and at the field maximum
    directed_rows.push_back('{make_item(KIND_PIXEL, FRAME_WIDTH, 0, 1, 0), 1,
                              make_result(STATUS_RANGE, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_PIXEL, 0, FRAME_HEIGHT, 1, 0), 1,
                              make_result(STATUS_RANGE, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_PIXEL, 511, 511, 1, 32767), 1,
                              make_result(STATUS_RANGE, BLACK_BYTE)});
    // corner pixels and one at the last bit of the first byte
    directed_rows.push_back('{make_item(KIND_PIXEL, 0, 0, 1, 0), 1,
                              make_result(STATUS_OK, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_PIXEL, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 1, 0), 1,
                              make_result(STATUS_OK, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_PIXEL, 7, 0, 1, 32767), 1,
                              make_result(STATUS_OK, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_READ, 0, 0, 0, 0), 0, '0});
    directed_rows.push_back('{make_item(KIND_READ, 0, 0, 0, FRAME_BYTES - 1), 0, '0});
    directed_rows.push_back('{make_item(KIND_PIXEL, 0, 0, 0, 0), 1,
                              make_result(STATUS_OK, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_READ, 511, 511, 1, 0), 0, '0});
    // black fill, then a white pixel on a black frame
    directed_rows.push_back('{make_item(KIND_FILL, 0, 0, 1, 0), 1,
                              make_result(STATUS_OK, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_READ, 0, 0, 0, 0), 1,
                              make_result(STATUS_OK, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_READ, 0, 0, 0, FRAME_BYTES - 1), 0, '0});
    directed_rows.push_back('{make_item(KIND_PIXEL, 100, 100, 0, 0), 1,
                              make_result(STATUS_OK, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_READ, 0, 0, 0, 100 * ROW_BYTES + 12), 0, '0});
    // white fill with the other fields at their maximum
    directed_rows.push_back('{make_item(KIND_FILL, 511, 511, 0, 32767), 1,
                              make_result(STATUS_OK, BLACK_BYTE)});
    directed_rows.push_back('{make_item(KIND_READ, 0, 0, 0, 12), 1,
                              make_result(STATUS_OK, WHITE_BYTE)});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles a third of the time, receiver three quarters
    send_idle_pct = 33;
    recv_idle_pct = 76;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer(row.item, row.typed, row.result);
    end
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 76;
      end else if (p < 6) begin
        send_idle_pct = 76;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_orientation(orient_seq[p]);
      // long receiver hold-off while the sender keeps offering
      if (p == 6) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        offer(random_transaction(), 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
